/* src/ppu_sar_pkg.sv */
// ----------------------------------------------------------------------------
// ppu_sar_pkg
// Types and constants shared by the scroll and address register unit.
// ----------------------------------------------------------------------------
package ppu_sar_pkg;

  localparam int unsigned AddrW = 15;

  localparam logic [AddrW-1:0] HorizBits    = 15'h041f;
  localparam logic [AddrW-1:0] VertBits     = 15'h7be0;
  localparam logic [AddrW-1:0] PaletteStart = 15'h3f00;

  typedef enum logic [3:0] {
    ModeCtrl    = 4'd0,
    ModeMask    = 4'd1,
    ModeStatus  = 4'd2,
    ModeScroll  = 4'd3,
    ModeAddr    = 4'd4,
    ModeDataWr  = 4'd5,
    ModeDataRd  = 4'd6,
    ModeIncX    = 4'd7,
    ModeIncY    = 4'd8,
    ModeCopyH   = 4'd9,
    ModeCopyV   = 4'd10,
    ModeVblank  = 4'd11,
    ModeClear   = 4'd12,
    ModeHit     = 4'd13
  } mode_e;

  typedef struct packed {
    logic [AddrW-1:0] temp_addr;
    logic [AddrW-1:0] cur_addr;
    logic [2:0]       fine_scroll;
    logic             first_write;
    logic [7:0]       read_buffer;
    logic             step_by_32;
    logic             nmi_enable;
    logic             show_background;
    logic             show_sprites;
    logic             vblank_flag;
    logic             sprite0_hit;
  } state_t;

  typedef struct packed {
    logic [AddrW-1:0] access_addr;
    logic [7:0]       read_data;
    logic [AddrW-1:0] vram_addr;
    logic [2:0]       fine_x;
    logic             nmi_request;
  } result_t;

endpackage

/* src/ppu_sar_step.sv */
// ----------------------------------------------------------------------------
// ppu_sar_step
// Next-state and result logic for one register access or timing event.
// ----------------------------------------------------------------------------
module ppu_sar_step (
  input  ppu_sar_pkg::state_t  state_i,
  input  logic [3:0]           mode_i,
  input  logic [7:0]           data_i,
  input  logic [7:0]           mem_data_i,
  output ppu_sar_pkg::state_t  state_o,
  output ppu_sar_pkg::result_t result_o
);

  logic [ppu_sar_pkg::AddrW-1:0] adv_addr;
  logic [ppu_sar_pkg::AddrW-1:0] inc_x_addr;
  logic [ppu_sar_pkg::AddrW-1:0] inc_y_addr;
  logic [ppu_sar_pkg::AddrW-1:0] addr_temp;
  logic [4:0]                    coarse_y;
  logic [7:0]                    rd;
  logic                          nmi;

  assign adv_addr = state_i.cur_addr +
                    (state_i.step_by_32 ? 15'd32 : 15'd1);

  always_comb begin
    inc_x_addr = state_i.cur_addr;
    if (state_i.cur_addr[4:0] == 5'd31) begin
      inc_x_addr[4:0] = 5'd0;
      inc_x_addr[10]  = ~state_i.cur_addr[10];
    end else begin
      inc_x_addr[4:0] = state_i.cur_addr[4:0] + 5'd1;
    end
  end

  always_comb begin
    inc_y_addr = state_i.cur_addr;
    coarse_y   = state_i.cur_addr[9:5];
    if (state_i.cur_addr[14:12] != 3'd7) begin
      inc_y_addr[14:12] = state_i.cur_addr[14:12] + 3'd1;
    end else begin
      inc_y_addr[14:12] = 3'd0;
      priority if (coarse_y == 5'd29) begin
        inc_y_addr[9:5] = 5'd0;
        inc_y_addr[11]  = ~state_i.cur_addr[11];
      end else if (coarse_y == 5'd31) begin
        inc_y_addr[9:5] = 5'd0;
      end else begin
        inc_y_addr[9:5] = coarse_y + 5'd1;
      end
    end
  end

  always_comb begin
    state_o   = state_i;
    rd        = 8'd0;
    nmi       = 1'b0;
    addr_temp = {state_i.temp_addr[14:8], data_i};
    unique case (ppu_sar_pkg::mode_e'(mode_i))
      ppu_sar_pkg::ModeCtrl: begin
        state_o.nmi_enable       = data_i[7];
        state_o.step_by_32       = data_i[2];
        state_o.temp_addr[11:10] = data_i[1:0];
      end
      ppu_sar_pkg::ModeMask: begin
        state_o.show_background = data_i[3];
        state_o.show_sprites    = data_i[4];
      end
      ppu_sar_pkg::ModeStatus: begin
        rd                  = {state_i.vblank_flag, state_i.sprite0_hit, 6'd0};
        state_o.vblank_flag = 1'b0;
        state_o.first_write = 1'b1;
      end
      ppu_sar_pkg::ModeScroll: begin
        if (state_i.first_write) begin
          state_o.temp_addr[4:0] = data_i[7:3];
          state_o.fine_scroll    = data_i[2:0];
        end else begin
          state_o.temp_addr[14:12] = data_i[2:0];
          state_o.temp_addr[9:5]   = data_i[7:3];
        end
        state_o.first_write = ~state_i.first_write;
      end
      ppu_sar_pkg::ModeAddr: begin
        if (state_i.first_write) begin
          state_o.temp_addr[14]   = 1'b0;
          state_o.temp_addr[13:8] = data_i[5:0];
        end else begin
          state_o.temp_addr = addr_temp;
          state_o.cur_addr  = addr_temp;
        end
        state_o.first_write = ~state_i.first_write;
      end
      ppu_sar_pkg::ModeDataWr: begin
        state_o.cur_addr = adv_addr;
      end
      ppu_sar_pkg::ModeDataRd: begin
        state_o.cur_addr = adv_addr;
        if (adv_addr < ppu_sar_pkg::PaletteStart) begin
          rd                  = state_i.read_buffer;
          state_o.read_buffer = mem_data_i;
        end else begin
          rd = mem_data_i;
        end
      end
      ppu_sar_pkg::ModeIncX: begin
        if (state_i.show_background) state_o.cur_addr = inc_x_addr;
      end
      ppu_sar_pkg::ModeIncY: begin
        if (state_i.show_background) state_o.cur_addr = inc_y_addr;
      end
      ppu_sar_pkg::ModeCopyH: begin
        if (state_i.show_background && state_i.show_sprites) begin
          state_o.cur_addr = (state_i.cur_addr & ~ppu_sar_pkg::HorizBits) |
                             (state_i.temp_addr & ppu_sar_pkg::HorizBits);
        end
      end
      ppu_sar_pkg::ModeCopyV: begin
        if (state_i.show_background && state_i.show_sprites) begin
          state_o.cur_addr = (state_i.cur_addr & ~ppu_sar_pkg::VertBits) |
                             (state_i.temp_addr & ppu_sar_pkg::VertBits);
        end
      end
      ppu_sar_pkg::ModeVblank: begin
        state_o.vblank_flag = 1'b1;
        nmi                 = state_i.nmi_enable;
      end
      ppu_sar_pkg::ModeClear: begin
        state_o.vblank_flag = 1'b0;
        state_o.sprite0_hit = 1'b0;
      end
      ppu_sar_pkg::ModeHit: begin
        state_o.sprite0_hit = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.access_addr = state_i.cur_addr;
    result_o.read_data   = rd;
    result_o.vram_addr   = state_o.cur_addr;
    result_o.fine_x      = state_o.fine_scroll;
    result_o.nmi_request = nmi;
  end

endmodule

/* src/ppu_sar_core_regs.sv */
// ----------------------------------------------------------------------------
// ppu_sar_core_regs
// Input register, scroll/address state and result register with stall flow.
// ----------------------------------------------------------------------------
module ppu_sar_core_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [3:0]           mode_i,
  input  logic [7:0]           data_i,
  input  logic [7:0]           mem_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ppu_sar_pkg::result_t result_o
);

  logic                 in_valid_q;
  logic [3:0]           mode_q;
  logic [7:0]           data_q;
  logic [7:0]           mem_data_q;
  logic                 out_valid_q;
  ppu_sar_pkg::result_t result_q;
  ppu_sar_pkg::state_t  state_q;
  ppu_sar_pkg::state_t  state_d;
  ppu_sar_pkg::result_t result_d;
  logic                 advance;
  logic                 in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  ppu_sar_step u_step (
    .state_i    (state_q),
    .mode_i     (mode_q),
    .data_i     (data_q),
    .mem_data_i (mem_data_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{temp_addr: '0, cur_addr: '0, fine_scroll: '0,
                       first_write: 1'b1, read_buffer: '0, step_by_32: 1'b0,
                       nmi_enable: 1'b0, show_background: 1'b1,
                       show_sprites: 1'b1, vblank_flag: 1'b0,
                       sprite0_hit: 1'b0};
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q     <= mode_i;
      data_q     <= data_i;
      mem_data_q <= mem_data_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

/* src/ppu_scroll_address_registers_core.sv */
// ----------------------------------------------------------------------------
// ppu_scroll_address_registers_core
// Scroll and address register unit of the picture processor.
// ----------------------------------------------------------------------------
// Takes one request per cycle (CPU register access or rendering timing event)
// and returns one result per request: the request is captured in an input
// register, the state update and result are computed in a single pass of
// logic and land in the result register. Stall on the result side holds
// the result register and then the input register, so throughput is one
// request per cycle whenever the output is not stalled.
module ppu_scroll_address_registers_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  mode_i,
  input  logic [7:0]  data_i,
  input  logic [7:0]  mem_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [14:0] access_addr_o,
  output logic [7:0]  read_data_o,
  output logic [14:0] vram_addr_o,
  output logic [2:0]  fine_x_o,
  output logic        nmi_request_o
);

  ppu_sar_pkg::result_t result;

  ppu_sar_core_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .data_i      (data_i),
    .mem_data_i  (mem_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign access_addr_o = result.access_addr;
  assign read_data_o   = result.read_data;
  assign vram_addr_o   = result.vram_addr;
  assign fine_x_o      = result.fine_x;
  assign nmi_request_o = result.nmi_request;

endmodule
